[sv/mst_pkg.sv]
package mst_pkg;

  // Graph size and weight width
  localparam int MaxVertices = 16;
  localparam int WeightBits  = 16;
  localparam int VIdxW       = $clog2(MaxVertices);
  localparam int CntW        = VIdxW + 1;
  localparam int MatDepth    = MaxVertices * MaxVertices;
  localparam int MatAddrW    = $clog2(MatDepth);
  localparam int CandW       = WeightBits + 1;

  // Field widths of the ports
  localparam int CountFieldW  = 5;
  localparam int IndexFieldW  = 4;
  localparam int WeightFieldW = 16;
  localparam int StatusW      = 2;

  // Best-candidate weight that means no edge reaches the vertex yet
  localparam logic [CandW-1:0] NoCand = {CandW{1'b1}};

  // Commands
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRun   = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] StatEdge         = 2'd0;
  localparam logic [StatusW-1:0] StatDisconnected = 2'd1;
  localparam logic [StatusW-1:0] StatSingle       = 2'd2;
  localparam logic [StatusW-1:0] StatBadStart     = 2'd3;

endpackage

[sv/prim_minimum_spanning_tree.sv]
// Prim minimum spanning tree over a stored 16 x 16 adjacency matrix. A write
// word (command 0) stores weight_value at row_index, column_index; a zero
// weight means no edge, and the matrix reads as all zeros after reset through
// one valid flag per entry, so no clearing pass is needed. A run word (command
// 1) grows a tree from start_vertex over the first vertex_count vertices (0
// counts as 1, values above 16 saturate) and returns one result word per tree
// edge, each the lightest edge leaving the tree so far, ties to the parent
// visited earliest and then to the lower child index; last marks the final
// word. A bad start, a single vertex or a graph that stops growing ends with
// one flagged word (status 3, 2 or 1) carrying zero vertices and weight. A run
// holds in_ready_o low while it lasts: every added vertex sweeps its matrix row
// through the single read port, one entry a cycle, behind the registered read,
// then StChoose picks the edge, waiting if the output stalls. The result sits in
// an output register, so the next word is taken while it waits.
module prim_minimum_spanning_tree
  import mst_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CountFieldW-1:0]  cfg_vertex_count_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    command_i,
  input  logic [IndexFieldW-1:0]  row_index_i,
  input  logic [IndexFieldW-1:0]  column_index_i,
  input  logic [WeightFieldW-1:0] weight_value_i,
  input  logic [IndexFieldW-1:0]  start_vertex_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IndexFieldW-1:0]  parent_vertex_o,
  output logic [IndexFieldW-1:0]  child_vertex_o,
  output logic [WeightFieldW-1:0] edge_weight_o,
  output logic [StatusW-1:0]      status_o,
  output logic                    last_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StVisit  = 2'd1;
  localparam logic [1:0] StChoose = 2'd2;
  localparam logic [1:0] StFlag   = 2'd3;

  logic [1:0] state_q, state_d;

  // Configuration register
  logic [CountFieldW-1:0] vcount_q;

  // Matrix store: RAM plus one valid flag per entry
  logic [MatDepth-1:0]   entry_valid_q, entry_valid_d;
  logic                  ram_we;
  logic [MatAddrW-1:0]   ram_waddr, ram_raddr;
  logic [WeightBits-1:0] ram_rdata;
  logic                  rd_valid_q;

  // Per-run vertex state
  logic [MaxVertices-1:0] visited_q, visited_d;
  logic [CandW-1:0]       bw_q [MaxVertices];
  logic [CandW-1:0]       bw_d [MaxVertices];
  logic [VIdxW-1:0]       bp_q [MaxVertices];
  logic [VIdxW-1:0]       bp_d [MaxVertices];
  logic [VIdxW-1:0]       br_q [MaxVertices];
  logic [VIdxW-1:0]       br_d [MaxVertices];

  // Sequencer registers
  logic [CntW-1:0]  n_q, n_d;
  logic [VIdxW-1:0] u_q, u_d;
  logic [VIdxW-1:0] rank_q, rank_d;
  logic [VIdxW-1:0] edges_q, edges_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pipe_v_q, pipe_v_d;
  logic [VIdxW-1:0] pipe_idx_q, pipe_idx_d;
  logic [StatusW-1:0] flag_q, flag_d;

  // Running minimum of the current sweep
  logic             found_q, found_d;
  logic [CandW-1:0] min_w_q, min_w_d;
  logic [VIdxW-1:0] min_rank_q, min_rank_d;
  logic [VIdxW-1:0] min_idx_q, min_idx_d;
  logic [VIdxW-1:0] min_par_q, min_par_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic [IndexFieldW-1:0]  parent_q, parent_d;
  logic [IndexFieldW-1:0]  child_q, child_d;
  logic [WeightFieldW-1:0] weight_q, weight_d;
  logic [StatusW-1:0]      status_q, status_d;
  logic                    last_q, last_d;

  logic in_fire;
  logic slot_free;
  logic [CntW-1:0] n_run;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Effective vertex count: zero reads as one, large values saturate
  always_comb begin
    if (vcount_q == '0) begin
      n_run = CntW'(1);
    end else if (32'(vcount_q) > MaxVertices) begin
      n_run = CntW'(MaxVertices);
    end else begin
      n_run = CntW'(vcount_q);
    end
  end

  mst_ram #(
    .Width(WeightBits),
    .Depth(MatDepth)
  ) u_matrix (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(WeightBits'(weight_value_i)),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ram_waddr = MatAddrW'({VIdxW'(row_index_i), VIdxW'(column_index_i)});
  assign ram_we    = in_fire && (command_i == CmdWrite) &&
                     (32'(row_index_i) < MaxVertices) &&
                     (32'(column_index_i) < MaxVertices);
  assign ram_raddr = MatAddrW'({u_q, cnt_q[VIdxW-1:0]});

  always_comb begin
    logic [CandW-1:0] w;
    logic [CandW-1:0] cand_w;
    logic [VIdxW-1:0] cand_rank;
    logic             upd;
    logic             better;
    logic             is_last;
    logic [VIdxW-1:0] edges_inc;

    state_d       = state_q;
    entry_valid_d = entry_valid_q;
    visited_d     = visited_q;
    bw_d          = bw_q;
    bp_d          = bp_q;
    br_d          = br_q;
    n_d           = n_q;
    u_d           = u_q;
    rank_d        = rank_q;
    edges_d       = edges_q;
    cnt_d         = cnt_q;
    pipe_v_d      = 1'b0;
    pipe_idx_d    = pipe_idx_q;
    flag_d        = flag_q;
    found_d       = found_q;
    min_w_d       = min_w_q;
    min_rank_d    = min_rank_q;
    min_idx_d     = min_idx_q;
    min_par_d     = min_par_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    parent_d      = parent_q;
    child_d       = child_q;
    weight_d      = weight_q;
    status_d      = status_q;
    last_d        = last_q;

    w         = rd_valid_q ? {1'b0, ram_rdata} : '0;
    upd       = !visited_q[pipe_idx_q] && (w != '0) && (w < bw_q[pipe_idx_q]);
    cand_w    = upd ? w : bw_q[pipe_idx_q];
    cand_rank = upd ? rank_q : br_q[pipe_idx_q];
    better    = !found_q || (cand_w < min_w_q) ||
                ((cand_w == min_w_q) && (cand_rank < min_rank_q));
    edges_inc = edges_q + VIdxW'(1);
    is_last   = (CntW'(edges_inc) == n_q - CntW'(1));

    if (ram_we) begin
      entry_valid_d[ram_waddr] = 1'b1;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire && (command_i == CmdRun)) begin
          // Clear the per-run state, then pick the start case
          n_d       = n_run;
          visited_d = '0;
          for (int i = 0; i < MaxVertices; i++) begin
            bw_d[i] = NoCand;
            bp_d[i] = '0;
            br_d[i] = '0;
          end
          edges_d = '0;
          if (32'(start_vertex_i) >= 32'(n_run)) begin
            flag_d  = StatBadStart;
            state_d = StFlag;
          end else if (n_run == CntW'(1)) begin
            flag_d  = StatSingle;
            state_d = StFlag;
          end else begin
            u_d                               = VIdxW'(start_vertex_i);
            visited_d[VIdxW'(start_vertex_i)] = 1'b1;
            rank_d                            = '0;
            cnt_d                             = '0;
            found_d                           = 1'b0;
            state_d                           = StVisit;
          end
        end
      end

      StVisit: begin
        // Issue the next row entry of u
        if (cnt_q < n_q) begin
          pipe_v_d   = 1'b1;
          pipe_idx_d = cnt_q[VIdxW-1:0];
          cnt_d      = cnt_q + CntW'(1);
        end
        // Relax the returned entry and fold it into the running minimum
        if (pipe_v_q) begin
          if (upd) begin
            bw_d[pipe_idx_q] = w;
            bp_d[pipe_idx_q] = u_q;
            br_d[pipe_idx_q] = rank_q;
          end
          if (!visited_q[pipe_idx_q] && (cand_w != NoCand) && better) begin
            found_d    = 1'b1;
            min_w_d    = cand_w;
            min_rank_d = cand_rank;
            min_idx_d  = pipe_idx_q;
            min_par_d  = upd ? u_q : bp_q[pipe_idx_q];
          end
          if (CntW'(pipe_idx_q) == n_q - CntW'(1)) begin
            state_d = StChoose;
          end
        end
      end

      StChoose: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (!found_q) begin
            parent_d = '0;
            child_d  = '0;
            weight_d = '0;
            status_d = StatDisconnected;
            last_d   = 1'b1;
            state_d  = StIdle;
          end else begin
            parent_d = IndexFieldW'(min_par_q);
            child_d  = IndexFieldW'(min_idx_q);
            weight_d = WeightFieldW'(min_w_q[WeightBits-1:0]);
            status_d = StatEdge;
            last_d   = is_last;
            edges_d  = edges_inc;
            if (is_last) begin
              state_d = StIdle;
            end else begin
              // Visit the new vertex next
              u_d                  = min_idx_q;
              visited_d[min_idx_q] = 1'b1;
              rank_d               = edges_inc;
              cnt_d                = '0;
              found_d              = 1'b0;
              state_d              = StVisit;
            end
          end
        end
      end

      StFlag: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          parent_d    = '0;
          child_d     = '0;
          weight_d    = '0;
          status_d    = flag_q;
          last_d      = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      vcount_q      <= CountFieldW'(1);
      entry_valid_q <= '0;
      visited_q     <= '0;
      edges_q       <= '0;
      cnt_q         <= '0;
      pipe_v_q      <= 1'b0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      rd_valid_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_vertex_count_i;
      end
      entry_valid_q <= entry_valid_d;
      visited_q     <= visited_d;
      edges_q       <= edges_d;
      cnt_q         <= cnt_d;
      pipe_v_q      <= pipe_v_d;
      found_q       <= found_d;
      out_valid_q   <= out_valid_d;
      rd_valid_q    <= entry_valid_q[ram_raddr];
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    bw_q       <= bw_d;
    bp_q       <= bp_d;
    br_q       <= br_d;
    n_q        <= n_d;
    u_q        <= u_d;
    rank_q     <= rank_d;
    pipe_idx_q <= pipe_idx_d;
    flag_q     <= flag_d;
    min_w_q    <= min_w_d;
    min_rank_q <= min_rank_d;
    min_idx_q  <= min_idx_d;
    min_par_q  <= min_par_d;
    parent_q   <= parent_d;
    child_q    <= child_d;
    weight_q   <= weight_d;
    status_q   <= status_d;
    last_q     <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign parent_vertex_o = parent_q;
  assign child_vertex_o  = child_q;
  assign edge_weight_o   = weight_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

`ifndef SYNTHESIS
  // Flagged words always close a run and carry no edge
  a_flag_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StatEdge) |-> last_o)
    else $error("flagged result without last");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StatEdge) |->
      (parent_vertex_o == '0) && (child_vertex_o == '0) && (edge_weight_o == '0))
    else $error("flagged result with nonzero payload");

  // The vertex whose row is swept is already in the tree
  a_sweep_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StVisit) |-> visited_q[u_q])
    else $error("sweeping a row of an unvisited vertex");

  // The chosen child is never a vertex already in the tree
  a_child_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StChoose) && found_q |-> !visited_q[min_idx_q])
    else $error("chosen child already visited");
`endif

endmodule

[sv/mst_ram.sv]
module mst_ram #(
  parameter  int Width = 16,
  parameter  int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
